### hw/rtl/tape_byte_pulse_encoder_macros.svh
// Assertion macros shared by the tape byte pulse encoder modules.
`ifndef TAPE_BYTE_PULSE_ENCODER_MACROS_SVH
`define TAPE_BYTE_PULSE_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TBPE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TBPE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tbpe_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the tape byte pulse encoder modules.
package tbpe_pkg;

    localparam int unsigned RUN_W = 6;
    localparam int unsigned CNT_W = 5;

    localparam logic [7:0] LEVEL_HIGH = 8'hF8;
    localparam logic [7:0] LEVEL_LOW  = 8'h08;

    localparam logic [RUN_W-1:0] TURBO_ONE_RUN  = 6'd4;
    localparam logic [RUN_W-1:0] TURBO_ZERO_RUN = 6'd2;
    localparam logic [RUN_W-1:0] TURBO_TOP_RUN  = 6'd3;
    localparam logic [RUN_W-1:0] SLOW_ONE_RESET  = 6'd13;
    localparam logic [RUN_W-1:0] SLOW_ZERO_RESET = 6'd39;

    // Index of the final run of a byte in each mode.
    localparam logic [CNT_W-1:0] SLOW_LAST_RUN  = 5'd15;
    localparam logic [CNT_W-1:0] TURBO_LAST_RUN = 5'd16;

    localparam logic [1:0] CMD_PLAIN    = 2'd0;
    localparam logic [1:0] CMD_SUM      = 2'd1;
    localparam logic [1:0] CMD_CHECKSUM = 2'd2;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_ONE_RUN  = 2'd1;
    localparam logic [1:0] REG_ZERO_RUN = 2'd2;

    localparam logic MODE_SLOW  = 1'b0;
    localparam logic MODE_TURBO = 1'b1;

    typedef struct packed {
        logic [7:0]       byte_val;
        logic             mode;
        logic [RUN_W-1:0] one_run;
        logic [RUN_W-1:0] zero_run;
    } tbpe_job_t;

endpackage

### hw/rtl/tbpe_front.sv
`timescale 1ns / 1ps
// Input stage: takes words, keeps the checksum and holds one encoding job.
`include "tape_byte_pulse_encoder_macros.svh"
module tbpe_front
    import tbpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] data_byte
    input  logic [1:0]       s_tuser,     // [1:0] cmd
    input  logic             cfg_mode,
    input  logic [RUN_W-1:0] cfg_one_run,
    input  logic [RUN_W-1:0] cfg_zero_run,
    input  logic             job_take,
    output logic             job_valid,
    output tbpe_job_t        job
);

    logic       accept;
    logic [7:0] checksum_reg;
    logic [7:0] checksum_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    tbpe_job_t  job_reg;
    tbpe_job_t  job_next;

    assign s_tready  = !job_valid_reg || job_take;
    assign accept    = s_tvalid && s_tready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        checksum_next = checksum_reg;
        if (accept)
        begin
            unique case (s_tuser)
                CMD_SUM:      checksum_next = checksum_reg + s_tdata;
                CMD_CHECKSUM: checksum_next = 8'd0;
                default:      checksum_next = checksum_reg;
            endcase
        end
    end

    always_comb
    begin
        job_next          = job_reg;
        job_valid_next    = job_valid_reg;
        if (accept)
        begin
            job_next.byte_val = (s_tuser == CMD_CHECKSUM) ? checksum_reg : s_tdata;
            job_next.mode     = cfg_mode;
            // A zero run length register acts as a length of one.
            job_next.one_run  = (cfg_one_run == '0) ? RUN_W'(1) : cfg_one_run;
            job_next.zero_run = (cfg_zero_run == '0) ? RUN_W'(1) : cfg_zero_run;
            job_valid_next    = 1'b1;
        end
        else if (job_take)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_reg  <= 8'd0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            checksum_reg  <= checksum_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    `TBPE_ASSERT_NEXT(a_checksum_cleared, accept && s_tuser == CMD_CHECKSUM,
        checksum_reg == 8'd0, "checksum not cleared after checksum send")
    `TBPE_ASSERT_NEXT(a_job_loaded, accept, job_valid_reg,
        "accepted word did not produce a job")
    `TBPE_ASSERT_SAME(a_runs_nonzero, job_valid_reg,
        job_reg.one_run != '0 && job_reg.zero_run != '0,
        "job holds a zero run length")

endmodule

### hw/rtl/tbpe_runs.sv
`timescale 1ns / 1ps
// Run generator: turns a job into level runs, one word per cycle when not stalled.
`include "tape_byte_pulse_encoder_macros.svh"
module tbpe_runs
    import tbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  tbpe_job_t   job,
    output logic        job_take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] level, [13:8] run_length, [15:14] zero
    output logic        m_tlast    // last
);

    tbpe_job_t        cur_reg;
    tbpe_job_t        cur_next;
    logic             active_reg;
    logic             active_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       level_reg;
    logic [7:0]       level_next;
    logic [RUN_W-1:0] len_reg;
    logic [RUN_W-1:0] len_next;
    logic             last_reg;
    logic             last_next;

    logic             out_free;
    logic             emit;
    logic             run_bit;
    logic [7:0]       run_level;
    logic [RUN_W-1:0] run_len;
    logic             run_last;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = active_reg && out_free;

    // Run pairs share one bit: cnt[3:1] picks the bit, cnt[0] the half.
    always_comb
    begin
        if (cur_reg.mode == MODE_SLOW)
        begin
            run_bit   = cur_reg.byte_val[~cnt_reg[3:1]];
            run_level = cnt_reg[0] ? LEVEL_LOW : LEVEL_HIGH;
            run_len   = run_bit ? cur_reg.one_run : cur_reg.zero_run;
            run_last  = (cnt_reg == SLOW_LAST_RUN);
        end
        else
        begin
            run_bit  = cur_reg.byte_val[cnt_reg[3:1]];
            run_last = (cnt_reg == TURBO_LAST_RUN);
            if (cnt_reg[0] || run_last)
            begin
                run_level = LEVEL_LOW;
                run_len   = TURBO_TOP_RUN;
            end
            else
            begin
                run_level = LEVEL_HIGH;
                run_len   = run_bit ? TURBO_ONE_RUN : TURBO_ZERO_RUN;
            end
        end
    end

    // A waiting job loads in the same cycle as the final run of the current one.
    assign job_take = job_valid && (!active_reg || (emit && run_last));

    always_comb
    begin
        cur_next    = cur_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (job_take)
        begin
            cur_next    = job;
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (emit)
        begin
            active_next = !run_last;
            cnt_next    = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            level_next     = run_level;
            len_next       = run_len;
            last_next      = run_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        level_reg <= level_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, len_reg, level_reg};
    assign m_tlast  = last_reg;

    `TBPE_ASSERT_NEXT(a_take_starts, job_take, active_reg && cnt_reg == '0,
        "taken job did not start at its first run")
    `TBPE_ASSERT_SAME(a_cnt_range, active_reg,
        (cur_reg.mode == MODE_SLOW && cnt_reg <= SLOW_LAST_RUN) ||
        (cur_reg.mode == MODE_TURBO && cnt_reg <= TURBO_LAST_RUN),
        "run counter past the end of the byte")
    `TBPE_ASSERT_SAME(a_high_not_last, out_valid_reg && level_reg == LEVEL_HIGH,
        !last_reg, "final run of a byte at the high level")

endmodule

### hw/rtl/tape_byte_pulse_encoder.sv
`timescale 1ns / 1ps
// Tape byte pulse encoder top level: configuration registers and the two stages.
// Input words arrive on s_tvalid/s_tready: the byte in s_tdata, the command in s_tuser.
// Each byte leaves as a run of output words on m_tvalid/m_tready, one level run each:
// level in m_tdata[7:0], run length in m_tdata[13:8], m_tlast on the byte's final run.
// Slow mode gives 16 runs per byte, turbo mode 17.
// The first run of a byte passes through the job slot, the run generator's current job
// and its output word register. Throughput is one output word per cycle while the
// receiver is ready, as the run counter in the run generator steps through the runs.
// A new input word is taken while the previous byte is still being sent, and runs of
// consecutive bytes follow each other with no gap. The configuration channel is always
// ready (cfg_valid, cfg_ready, cfg_index, cfg_data); the user must make writes only
// while no byte is in flight, as the block does not enforce this. Index 0 is the mode,
// 1 the run length for a 1 bit and 2 that for a 0 bit in slow mode.
// Reset clears the checksum, drops all pending bytes and restores slow mode with
// run lengths 13 and 39.
// When the receiver stalls, the current output word holds, the run generator waits,
// and once the one job slot is full the input side deasserts s_tready.
module tape_byte_pulse_encoder
    import tbpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] data_byte
    input  logic [1:0]       s_tuser,    // [1:0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [7:0] level, [13:8] run_length, [15:14] zero
    output logic             m_tlast,    // last
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [RUN_W-1:0] cfg_data
);

    logic             cfg_write;
    logic             mode_reg;
    logic             mode_next;
    logic [RUN_W-1:0] one_run_reg;
    logic [RUN_W-1:0] one_run_next;
    logic [RUN_W-1:0] zero_run_reg;
    logic [RUN_W-1:0] zero_run_next;
    logic             job_valid;
    logic             job_take;
    tbpe_job_t        job;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        mode_next     = mode_reg;
        one_run_next  = one_run_reg;
        zero_run_next = zero_run_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_next     = cfg_data[0];
                REG_ONE_RUN:  one_run_next  = cfg_data;
                REG_ZERO_RUN: zero_run_next = cfg_data;
                default:      mode_next     = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SLOW;
            one_run_reg  <= SLOW_ONE_RESET;
            zero_run_reg <= SLOW_ZERO_RESET;
        end
        else
        begin
            mode_reg     <= mode_next;
            one_run_reg  <= one_run_next;
            zero_run_reg <= zero_run_next;
        end
    end

    tbpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_mode     (mode_reg),
        .cfg_one_run  (one_run_reg),
        .cfg_zero_run (zero_run_reg),
        .job_take     (job_take),
        .job_valid    (job_valid),
        .job          (job)
    );

    tbpe_runs u_runs (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### bench/tape_run_checker.sv
`timescale 1ns / 1ps
// Watches the encoder's channels, predicts every level run and compares it with the output.
module tape_run_checker
    import tbpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,
    input  logic             m_tlast,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [RUN_W-1:0] cfg_data,
    output int               fail_count,
    output int               runs_pending,
    output int               runs_checked
);

    typedef struct packed {
        logic [7:0]       level;
        logic [RUN_W-1:0] run_len;
        logic             last;
    } tape_run_t;

    tape_run_t        expected_runs[$];
    logic [7:0]       running_sum;
    logic             enc_mode;
    logic [RUN_W-1:0] one_len;
    logic [RUN_W-1:0] zero_len;
    int               n_fail;
    int               n_checked;

    function automatic tape_run_t make_run(input logic [7:0] level,
                                           input logic [RUN_W-1:0] run_len,
                                           input logic last);
        tape_run_t r;
        r.level   = level;
        r.run_len = run_len;
        r.last    = last;
        return r;
    endfunction

    // Applies the command to the running sum and queues the runs of one byte.
    task automatic queue_byte_runs(input logic [1:0] cmd, input logic [7:0] data);
        logic [7:0]       tape_byte;
        logic [RUN_W-1:0] r1;
        logic [RUN_W-1:0] r0;
        logic [RUN_W-1:0] len;
        int               i;
        tape_byte = data;
        if (cmd == CMD_CHECKSUM)
        begin
            tape_byte   = running_sum;
            running_sum = '0;
        end
        else if (cmd == CMD_SUM)
        begin
            running_sum = running_sum + data;
        end
        if (enc_mode == MODE_SLOW)
        begin
            // A run length register that holds zero still gives one sample.
            r1 = (one_len == '0) ? 6'd1 : one_len;
            r0 = (zero_len == '0) ? 6'd1 : zero_len;
            for (i = 0; i < 8; i++)
            begin
                len = tape_byte[7 - i] ? r1 : r0;
                expected_runs.push_back(make_run(LEVEL_HIGH, len, 1'b0));
                expected_runs.push_back(make_run(LEVEL_LOW, len, i == 7));
            end
        end
        else
        begin
            for (i = 0; i < 8; i++)
            begin
                len = tape_byte[i] ? TURBO_ONE_RUN : TURBO_ZERO_RUN;
                expected_runs.push_back(make_run(LEVEL_HIGH, len, 1'b0));
                expected_runs.push_back(make_run(LEVEL_LOW, TURBO_TOP_RUN, 1'b0));
            end
            expected_runs.push_back(make_run(LEVEL_LOW, TURBO_TOP_RUN, 1'b1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tape_run_t want;
        if (!rst_n)
        begin
            expected_runs.delete();
            running_sum  = '0;
            enc_mode     = MODE_SLOW;
            one_len      = SLOW_ONE_RESET;
            zero_len     = SLOW_ZERO_RESET;
            n_fail       = 0;
            n_checked    = 0;
            fail_count   <= 0;
            runs_pending <= 0;
            runs_checked <= 0;
        end
        else
        begin
            // A run leaving now can never belong to a word taken at this edge.
            if (m_tvalid && m_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected run word %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (m_tdata[7:0] !== want.level || m_tdata[13:8] !== want.run_len
                        || m_tdata[15:14] !== 2'b00 || m_tlast !== want.last)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("run %0d: expected level %h len %0d last %b,",
                                     n_checked, want.level, want.run_len, want.last,
                                     " got %h %0d %b pad %b",
                                     m_tdata[7:0], m_tdata[13:8], m_tlast, m_tdata[15:14]);
                    end
                end
                n_checked++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:     enc_mode = cfg_data[0];
                    REG_ONE_RUN:  one_len  = cfg_data;
                    REG_ZERO_RUN: zero_len = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                queue_byte_runs(s_tuser, s_tdata);
            fail_count   <= n_fail;
            runs_pending <= expected_runs.size();
            runs_checked <= n_checked;
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the tape byte pulse encoder testbench: clock, reset, stimulus and verdict.
module tb;
    import tbpe_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 12;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [RUN_W-1:0] cfg_data = '0;

    int fail_count;
    int runs_pending;
    int runs_checked;

    int cycles = 0;
    int words_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int gap_max = 0;
    int rx_style = 0;
    int rx_period = 4;
    int rx_hold = 1;
    int rx_phase = 0;

    tape_byte_pulse_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tape_run_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .runs_pending (runs_pending),
        .runs_checked (runs_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout with %0d runs still expected", runs_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: always ready, random, or a fixed stall window per period.
    always @(posedge clk)
    begin
        rx_phase <= (rx_phase + 1) % rx_period;
        case (rx_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) < 60);
            default: m_tready <= (rx_phase >= rx_hold);
        endcase
    end

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Waits until every predicted run has come out and the pipeline has emptied.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (runs_pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [RUN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_encoding(input logic mode, input logic [RUN_W-1:0] one_len,
                                input logic [RUN_W-1:0] zero_len);
        drain();
        write_reg(REG_MODE, {5'b0, mode});
        write_reg(REG_ONE_RUN, one_len);
        write_reg(REG_ZERO_RUN, zero_len);
        settings_used++;
    endtask

    function automatic logic [RUN_W-1:0] pick_run_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return 6'd1;
        else if (roll == 2)
            return 6'd63;
        return RUN_W'($urandom_range(1, 63));
    endfunction

    function automatic logic [1:0] pick_cmd();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 8)
            return CMD_PLAIN;
        else if (roll < 16)
            return CMD_SUM;
        else if (roll < 19)
            return CMD_CHECKSUM;
        return CMD_SPARE;
    endfunction

    initial
    begin
        int phase;
        int n;
        logic [7:0] data;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: slow mode with the default run lengths.
        gap_max  = 2;
        rx_style = 0;
        send_word(CMD_PLAIN, 8'h00);
        send_word(CMD_SUM, 8'hFF);
        send_word(CMD_SUM, 8'hA5);
        send_word(CMD_CHECKSUM, 8'h00);
        send_word(CMD_SPARE, 8'h5A);

        // Turbo mode; the sum wraps past 255 and the checksum byte goes out in turbo form.
        rx_style = 1;
        set_encoding(MODE_TURBO, 6'd13, 6'd39);
        send_word(CMD_SUM, 8'hFF);
        send_word(CMD_SUM, 8'h02);
        send_word(CMD_PLAIN, 8'h80);
        send_word(CMD_CHECKSUM, 8'hFF);
        send_word(CMD_SPARE, 8'h00);
        send_word(CMD_CHECKSUM, 8'h00);

        // Extreme run lengths in slow mode, and a write to the unused index.
        rx_style  = 2;
        rx_period = 5;
        rx_hold   = 3;
        set_encoding(MODE_SLOW, 6'd63, 6'd1);
        write_reg(REG_SPARE, 6'd21);
        send_word(CMD_SUM, 8'hF0);
        send_word(CMD_PLAIN, 8'h0F);
        send_word(CMD_CHECKSUM, 8'h33);

        // Zero run lengths act as one sample.
        set_encoding(MODE_SLOW, 6'd0, 6'd0);
        send_word(CMD_PLAIN, 8'h3C);
        send_word(CMD_SUM, 8'hC3);

        set_encoding(MODE_SLOW, 6'd1, 6'd63);
        send_word(CMD_SPARE, 8'h96);
        send_word(CMD_CHECKSUM, 8'h00);
        send_word(CMD_SUM, 8'h01);

        // Random phases, each with its own settings, sender gap limit and receiver style.
        for (phase = 0; phase < 7; phase++)
        begin
            rx_style  = $urandom_range(0, 2);
            rx_period = $urandom_range(2, 9);
            rx_hold   = $urandom_range(1, rx_period - 1);
            gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 6);
            set_encoding(1'($urandom_range(0, 1)), pick_run_len(), pick_run_len());
            for (n = 0; n < 27; n++)
            begin
                data = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    data = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                send_word(pick_cmd(), data);
            end
        end

        drain();
        $display("sent %0d bytes under %0d encoder settings plus reset defaults", words_sent,
                 settings_used);
        $display("checked %0d level runs in slow and turbo mode", runs_checked);
        if (fail_count == 0 && runs_pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d runs missing", fail_count, runs_pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tbpe_pkg.sv
hw/rtl/tbpe_front.sv
hw/rtl/tbpe_runs.sv
hw/rtl/tape_byte_pulse_encoder.sv
bench/tape_run_checker.sv
bench/tb.sv
